FILE: rtl/core/pomodoro_countdown_controller_top_assert.svh
// Assertion macros for the countdown controller
`ifndef POMODORO_COUNTDOWN_CONTROLLER_TOP_ASSERT_SVH
`define POMODORO_COUNTDOWN_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    typedef enum logic [1:0] {
        PH_WORK     = 2'd0,
        PH_SHORT    = 2'd1,
        PH_LONG     = 2'd2,
        PH_SETTINGS = 2'd3
    } phase_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_KEY  = 1'b1
    } command_t;

    localparam logic [1:0] EDIT_NONE  = 2'd0;
    localparam logic [1:0] EDIT_WORK  = 2'd1;
    localparam logic [1:0] EDIT_BREAK = 2'd2;
    localparam logic [1:0] EDIT_LONG  = 2'd3;

    localparam logic [1:0] REG_WORK_SEC  = 2'd0;
    localparam logic [1:0] REG_BREAK_SEC = 2'd1;
    localparam logic [1:0] REG_LONG_SEC  = 2'd2;
    localparam logic [1:0] REG_SESSIONS  = 2'd3;

    localparam logic [7:0] KEY_STAR   = 8'h2A;
    localparam logic [7:0] KEY_SLASH  = 8'h2F;
    localparam logic [7:0] KEY_EQUALS = 8'h3D;
    localparam logic [7:0] KEY_ZERO   = 8'h30;
    localparam logic [7:0] KEY_NINE   = 8'h39;

    localparam logic [5:0] SEC_WRAP      = 6'd59;
    localparam logic [1:0] BUZZ_DURATION = 2'd2;
    localparam logic [6:0] SESSIONS_RST  = 7'd4;

    localparam int unsigned RESULT_W = 44;
    localparam int unsigned TDATA_W  = 48;

    // first field in the highest bits
    typedef struct packed {
        logic [3:0] first_digit;
        logic       edit_digit_pos;
        logic [1:0] edit_field;
        logic [6:0] sessions_done;
        logic       buzzer_on;
        logic [5:0] break_seconds_left;
        logic [6:0] break_minutes_left;
        logic [5:0] work_seconds_left;
        logic [6:0] work_minutes_left;
        logic       running;
        logic [1:0] phase;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pomodoro_countdown_controller_top.sv
// Pomodoro countdown controller.
// Input channel (s_*): one transaction is a one-second tick (s_tuser = 0) or a
// keypad key (s_tuser = 1, ASCII code in s_tdata). Each accepted transaction
// updates the timer state and yields exactly one status transaction on the
// output channel (m_*): phase, run flag, work and break counters, buzzer,
// session count and settings cursor.
// The status is registered, in the skid entry if the output register is stalled.
// One transaction per cycle while m_tready is high; the whole state update is
// one combinational pass between the state registers and the output register.
// Stall: an output register plus one skid entry decouple the channels; with the
// receiver stalled one more input is taken, then s_tready drops until the
// output drains. No transaction is lost or repeated.
// Configuration: APB-style port, start-seconds registers at 0x0, 0x4, 0x8 and
// the long-break session threshold at 0xC. Write only while the stream idles.
// Reset (aresetn low, synchronous): work phase, stopped, minute settings and
// counters at their defaults, seconds at zero, buzzer and sessions cleared,
// output channel empty.
`default_nettype none

module pomodoro_countdown_controller_top #(
    parameter int unsigned WORK_MINUTES_DEFAULT       = 25,
    parameter int unsigned BREAK_MINUTES_DEFAULT      = 5,
    parameter int unsigned LONG_BREAK_MINUTES_DEFAULT = 15
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [7:0]                   s_tdata,  // [7:0] key_code
    input  wire logic                         s_tuser,  // [0] command
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // [1:0] phase, [2] running, [9:3] work_minutes_left, [15:10] work_seconds_left,
    // [22:16] break_minutes_left, [28:23] break_seconds_left, [29] buzzer_on,
    // [36:30] sessions_done, [38:37] edit_field, [39] edit_digit_pos,
    // [43:40] first_digit, [47:44] zero
    output      logic [pcc_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready
);

    localparam logic [6:0] WORK_MIN_RST  = 7'(WORK_MINUTES_DEFAULT);
    localparam logic [6:0] BREAK_MIN_RST = 7'(BREAK_MINUTES_DEFAULT);
    localparam logic [6:0] LONG_MIN_RST  = 7'(LONG_BREAK_MINUTES_DEFAULT);

    // configuration
    logic [5:0] work_start_sec_reg;
    logic [5:0] break_start_sec_reg;
    logic [5:0] long_start_sec_reg;
    logic [6:0] sessions_limit_reg;
    logic       cfg_write;

    // timer state
    pcc_pkg::phase_t phase_reg, phase_next;
    logic       running_reg, running_next;
    logic [6:0] set_work_min_reg, set_work_min_next;
    logic [6:0] set_break_min_reg, set_break_min_next;
    logic [6:0] set_long_min_reg, set_long_min_next;
    logic [6:0] work_min_reg, work_min_next;
    logic [5:0] work_sec_reg, work_sec_next;
    logic [6:0] break_min_reg, break_min_next;
    logic [5:0] break_sec_reg, break_sec_next;
    logic [6:0] session_reg, session_next;
    logic [1:0] buzz_reg, buzz_next;
    logic [1:0] edit_index_reg, edit_index_next;
    logic       edit_cursor_reg, edit_cursor_next;
    logic [3:0] digit0_reg, digit0_next;

    // output register and skid entry
    pcc_pkg::result_t result_next;
    pcc_pkg::result_t out_data_reg, out_data_next;
    pcc_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    logic in_xfer;
    logic out_xfer;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign s_tready  = ~skid_valid_reg;
    assign in_xfer   = s_tvalid & s_tready;
    assign out_xfer  = out_valid_reg & m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(pcc_pkg::TDATA_W - pcc_pkg::RESULT_W)'(0), out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_start_sec_reg  <= '0;
            break_start_sec_reg <= '0;
            long_start_sec_reg  <= '0;
            sessions_limit_reg  <= pcc_pkg::SESSIONS_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                pcc_pkg::REG_WORK_SEC:  work_start_sec_reg  <= pwdata[5:0];
                pcc_pkg::REG_BREAK_SEC: break_start_sec_reg <= pwdata[5:0];
                pcc_pkg::REG_LONG_SEC:  long_start_sec_reg  <= pwdata[5:0];
                pcc_pkg::REG_SESSIONS:  sessions_limit_reg  <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pcc_pkg::REG_WORK_SEC:  prdata = {26'd0, work_start_sec_reg};
            pcc_pkg::REG_BREAK_SEC: prdata = {26'd0, break_start_sec_reg};
            pcc_pkg::REG_LONG_SEC:  prdata = {26'd0, long_start_sec_reg};
            pcc_pkg::REG_SESSIONS:  prdata = {25'd0, sessions_limit_reg};
            default:                prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        logic       timer_rst;
        logic       field_step;
        logic [6:0] session_inc;
        logic [3:0] digit;
        logic [6:0] entry_value;

        phase_next         = phase_reg;
        running_next       = running_reg;
        set_work_min_next  = set_work_min_reg;
        set_break_min_next = set_break_min_reg;
        set_long_min_next  = set_long_min_reg;
        work_min_next      = work_min_reg;
        work_sec_next      = work_sec_reg;
        break_min_next     = break_min_reg;
        break_sec_next     = break_sec_reg;
        session_next       = session_reg;
        buzz_next          = buzz_reg;
        edit_index_next    = edit_index_reg;
        edit_cursor_next   = edit_cursor_reg;
        digit0_next        = digit0_reg;
        timer_rst          = 1'b0;
        field_step         = 1'b0;
        session_inc        = session_reg + 7'd1;
        digit              = 4'(s_tdata - pcc_pkg::KEY_ZERO);
        entry_value        = 7'({digit0_reg, 3'b000}) + 7'({digit0_reg, 1'b0}) + 7'(digit);

        if (s_tuser == pcc_pkg::CMD_TICK) begin
            if (buzz_reg != 2'd0) begin
                buzz_next = buzz_reg - 2'd1;
            end
            if (running_reg) begin
                if (phase_reg == pcc_pkg::PH_WORK) begin
                    if (work_sec_reg != 6'd0) begin
                        work_sec_next = work_sec_reg - 6'd1;
                    end else if (work_min_reg != 7'd0) begin
                        work_min_next = work_min_reg - 7'd1;
                        work_sec_next = pcc_pkg::SEC_WRAP;
                    end else begin
                        buzz_next = pcc_pkg::BUZZ_DURATION;
                        if (session_inc >= sessions_limit_reg) begin
                            phase_next     = pcc_pkg::PH_LONG;
                            break_min_next = set_long_min_reg;
                            break_sec_next = long_start_sec_reg;
                            session_next   = '0;
                        end else begin
                            phase_next     = pcc_pkg::PH_SHORT;
                            break_min_next = set_break_min_reg;
                            break_sec_next = break_start_sec_reg;
                            session_next   = session_inc;
                        end
                    end
                end else begin
                    if (break_sec_reg != 6'd0) begin
                        break_sec_next = break_sec_reg - 6'd1;
                    end else if (break_min_reg != 7'd0) begin
                        break_min_next = break_min_reg - 7'd1;
                        break_sec_next = pcc_pkg::SEC_WRAP;
                    end else begin
                        phase_next    = pcc_pkg::PH_WORK;
                        work_min_next = set_work_min_reg;
                        work_sec_next = work_start_sec_reg;
                        buzz_next     = pcc_pkg::BUZZ_DURATION;
                        running_next  = 1'b0;
                    end
                end
            end
        end else if (s_tdata == pcc_pkg::KEY_STAR) begin
            if (phase_reg != pcc_pkg::PH_SETTINGS) begin
                phase_next      = pcc_pkg::PH_SETTINGS;
                edit_index_next = pcc_pkg::EDIT_WORK;
                running_next    = 1'b0;
            end else begin
                field_step = 1'b1;
            end
            edit_cursor_next = 1'b0;
        end else if (phase_reg == pcc_pkg::PH_SETTINGS) begin
            if (s_tdata inside {[pcc_pkg::KEY_ZERO:pcc_pkg::KEY_NINE]}) begin
                if (!edit_cursor_reg) begin
                    digit0_next      = digit;
                    edit_cursor_next = 1'b1;
                end else begin
                    case (edit_index_reg)
                        pcc_pkg::EDIT_WORK:  set_work_min_next  = entry_value;
                        pcc_pkg::EDIT_BREAK: set_break_min_next = entry_value;
                        pcc_pkg::EDIT_LONG:  set_long_min_next  = entry_value;
                        default: begin
                        end
                    endcase
                    edit_cursor_next = 1'b0;
                    field_step       = 1'b1;
                end
            end else if (s_tdata == pcc_pkg::KEY_EQUALS) begin
                edit_index_next = pcc_pkg::EDIT_NONE;
                timer_rst       = 1'b1;
            end
        end else begin
            if (s_tdata == pcc_pkg::KEY_SLASH) begin
                running_next = ~running_reg;
            end else if (s_tdata == pcc_pkg::KEY_EQUALS) begin
                timer_rst = 1'b1;
            end
        end

        if (field_step) begin
            if (edit_index_reg == pcc_pkg::EDIT_LONG) begin
                edit_index_next = pcc_pkg::EDIT_NONE;
                timer_rst       = 1'b1;
            end else begin
                edit_index_next = edit_index_reg + 2'd1;
            end
        end

        // reload from the freshly written minute settings
        if (timer_rst) begin
            running_next   = 1'b0;
            phase_next     = pcc_pkg::PH_WORK;
            session_next   = '0;
            work_min_next  = set_work_min_next;
            work_sec_next  = work_start_sec_reg;
            break_min_next = set_break_min_next;
            break_sec_next = break_start_sec_reg;
        end
    end

    // status assembled from the updated state
    always_comb begin
        result_next.phase              = phase_next;
        result_next.running            = running_next;
        result_next.work_minutes_left  = work_min_next;
        result_next.work_seconds_left  = work_sec_next;
        result_next.break_minutes_left = break_min_next;
        result_next.break_seconds_left = break_sec_next;
        result_next.buzzer_on          = (buzz_next != 2'd0);
        result_next.sessions_done      = session_next;
        result_next.edit_field         = edit_index_next;
        result_next.edit_digit_pos     = edit_cursor_next;
        result_next.first_digit        = digit0_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= pcc_pkg::PH_WORK;
            running_reg       <= 1'b0;
            set_work_min_reg  <= WORK_MIN_RST;
            set_break_min_reg <= BREAK_MIN_RST;
            set_long_min_reg  <= LONG_MIN_RST;
            work_min_reg      <= WORK_MIN_RST;
            work_sec_reg      <= '0;
            break_min_reg     <= BREAK_MIN_RST;
            break_sec_reg     <= '0;
            session_reg       <= '0;
            buzz_reg          <= '0;
            edit_index_reg    <= pcc_pkg::EDIT_NONE;
            edit_cursor_reg   <= 1'b0;
            digit0_reg        <= '0;
        end else if (in_xfer) begin
            phase_reg         <= phase_next;
            running_reg       <= running_next;
            set_work_min_reg  <= set_work_min_next;
            set_break_min_reg <= set_break_min_next;
            set_long_min_reg  <= set_long_min_next;
            work_min_reg      <= work_min_next;
            work_sec_reg      <= work_sec_next;
            break_min_reg     <= break_min_next;
            break_sec_reg     <= break_sec_next;
            session_reg       <= session_next;
            buzz_reg          <= buzz_next;
            edit_index_reg    <= edit_index_next;
            edit_cursor_reg   <= edit_cursor_next;
            digit0_reg        <= digit0_next;
        end
    end

    // output slot and skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_xfer || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (in_xfer) begin
                out_valid_next = 1'b1;
                out_data_next  = result_next;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_xfer) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`include "pomodoro_countdown_controller_top_assert.svh"

    `PCC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid entry held while output slot empty")
    `PCC_ASSERT_NOW(a_settings_stopped, aclk, aresetn, phase_reg == pcc_pkg::PH_SETTINGS, !running_reg, "countdown running in settings mode")
    `PCC_ASSERT_NOW(a_edit_matches_phase, aclk, aresetn, 1'b1, (phase_reg == pcc_pkg::PH_SETTINGS) == (edit_index_reg != pcc_pkg::EDIT_NONE), "edit field out of step with settings phase")
    `PCC_ASSERT_NEXT(a_key_keeps_buzzer, aclk, aresetn, in_xfer && (s_tuser == pcc_pkg::CMD_KEY), $stable(buzz_reg), "key press changed the buzzer count")

endmodule

`default_nettype wire
